// ----- rtl/irwd_pkg.sv -----
package irwd_pkg;

    // Result kinds, carried on the output tuser.
    typedef enum logic [2:0] {
        KIND_TIME_BASE = 3'd0,
        KIND_DICT      = 3'd1,
        KIND_COUNT     = 3'd2,
        KIND_RUN       = 3'd3,
        KIND_RAW       = 3'd4,
        KIND_REJECT    = 3'd5
    } kind_t;

    // Message parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_FLAGS = 5'b00001,
        PH_DLEN  = 5'b00010,
        PH_DICT  = 5'b00100,
        PH_COUNT = 5'b01000,
        PH_BODY  = 5'b10000
    } phase_t;

    localparam logic [3:0] NIB_ESC         = 4'hF;
    localparam logic [2:0] RAW_NIBBLES     = 3'd4;
    localparam int         FLAG_COMPRESSED = 7;
    localparam logic [6:0] TIME_BASE_MASK  = 7'h7F;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  slot;
        logic [15:0] value;
        logic [8:0]  run_len;
        logic        last;
    } result_t;

    // Decoder state that the body nibbles work on.
    typedef struct packed {
        logic        count_escape;
        logic [2:0]  raw_left;
        logic [15:0] raw_accum;
        logic [3:0]  cur_symbol;
        logic [7:0]  cmd_pos;
        logic [7:0]  raw_pos;
    } body_t;

    typedef struct packed {
        body_t   st;
        logic    fire;
        result_t res;
    } nib_out_t;

    // Decodes one body nibble against the body state.
    function automatic nib_out_t body_nibble(body_t st, logic [3:0] v);
        nib_out_t   o;
        logic [8:0] len;
        o.st          = st;
        o.fire        = 1'b0;
        o.res.kind    = KIND_RUN;
        o.res.slot    = 8'd0;
        o.res.value   = 16'd0;
        o.res.run_len = 9'd1;
        o.res.last    = 1'b0;
        len           = 9'd1;
        if (st.raw_left != 3'd0)
        begin
            o.st.raw_accum = {st.raw_accum[11:0], v};
            o.st.raw_left  = st.raw_left - 3'd1;
            if (st.raw_left == 3'd1)
            begin
                o.fire       = 1'b1;
                o.res.kind   = KIND_RAW;
                o.res.slot   = st.raw_pos;
                o.res.value  = o.st.raw_accum;
                o.st.raw_pos = st.raw_pos + 8'd1;
                o.st.cmd_pos = st.cmd_pos + 8'd1;
            end
        end
        else if (v != NIB_ESC)
        begin
            if (st.count_escape)
            begin
                len = (v == 4'd0) ? 9'd256 : {5'd0, v};
                o.st.count_escape = 1'b0;
            end
            else
            begin
                o.st.cur_symbol = v;
            end
            o.fire        = 1'b1;
            o.res.kind    = KIND_RUN;
            o.res.slot    = st.cmd_pos;
            o.res.value   = {12'd0, o.st.cur_symbol};
            o.res.run_len = len;
            o.st.cmd_pos  = st.cmd_pos + len[7:0];
        end
        else if (st.count_escape)
        begin
            o.st.raw_accum    = 16'd0;
            o.st.raw_left     = RAW_NIBBLES;
            o.st.count_escape = 1'b0;
        end
        else
        begin
            o.st.count_escape = 1'b1;
        end
        return o;
    endfunction

endpackage

// ----- rtl/ir_wave_message_decoder.sv -----
// Infrared waveform message decoder. Message bytes enter on the slave stream,
// with tlast on the final byte of a message; decoded items leave on the master
// stream, one per beat, with the item kind on tuser and tlast on the final
// item caused by one input byte. A byte is taken into an input register and
// decoded into at most two items, which go into a two-entry result queue.
// Header bytes and body bytes that yield at most one item are taken at one
// byte per cycle while the master stream takes every beat; after a body byte
// whose two nibbles both yield an item, the next byte is not decoded until
// the second item leaves, as the single output beat per cycle drains the
// result queue. A message whose flags byte has bit 7 clear yields one
// rejected item and nothing more until its final byte.
module ir_wave_message_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tlast,   // end_of_msg
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] slot, [23:8] value, [32:24] run_length
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last_of_item
);
    import irwd_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state.
    phase_t     phase_reg, phase_next;
    logic [7:0] dict_left_reg, dict_left_next;
    logic [7:0] dict_slot_reg, dict_slot_next;
    logic       low_seen_reg, low_seen_next;
    logic [7:0] low_byte_reg, low_byte_next;
    logic       rejecting_reg, rejecting_next;
    body_t      body_reg, body_next;

    // Result queue: head is on the master stream, tail waits behind it.
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       pop;
    logic [1:0] remaining;
    logic       proc_fire;
    logic       in_fire;
    result_t    res0, res1;
    logic [1:0] n_res;
    nib_out_t   nib_hi, nib_lo;

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign remaining     = cnt_reg - {1'b0, pop};
    // A byte is decoded only when the queue will be empty after this beat,
    // so both of its items always fit.
    assign proc_fire     = in_valid_reg && (remaining == 2'd0);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {7'd0, head_reg.run_len, head_reg.value, head_reg.slot};
    assign m_axis_tuser  = head_reg.kind;
    assign m_axis_tlast  = head_reg.last;

    always_comb
    begin
        phase_next     = phase_reg;
        dict_left_next = dict_left_reg;
        dict_slot_next = dict_slot_reg;
        low_seen_next  = low_seen_reg;
        low_byte_next  = low_byte_reg;
        rejecting_next = rejecting_reg;
        body_next      = body_reg;

        res0.kind    = KIND_TIME_BASE;
        res0.slot    = 8'd0;
        res0.value   = 16'd0;
        res0.run_len = 9'd1;
        res0.last    = 1'b1;
        res1         = res0;
        n_res        = 2'd0;

        nib_hi = body_nibble(body_reg, in_byte_reg[7:4]);
        nib_lo = body_nibble(nib_hi.st, in_byte_reg[3:0]);

        if (!rejecting_reg)
        begin
            case (phase_reg)
                PH_FLAGS:
                begin
                    n_res = 2'd1;
                    if (!in_byte_reg[FLAG_COMPRESSED])
                    begin
                        res0.kind      = KIND_REJECT;
                        rejecting_next = 1'b1;
                    end
                    else
                    begin
                        res0.kind  = KIND_TIME_BASE;
                        res0.value = {9'd0, in_byte_reg[6:0] & TIME_BASE_MASK};
                        phase_next = PH_DLEN;
                    end
                end
                PH_DLEN:
                begin
                    dict_left_next = in_byte_reg;
                    dict_slot_next = 8'd0;
                    low_seen_next  = 1'b0;
                    phase_next     = (in_byte_reg == 8'd0) ? PH_COUNT : PH_DICT;
                end
                PH_DICT:
                begin
                    if (!low_seen_reg)
                    begin
                        low_byte_next = in_byte_reg;
                        low_seen_next = 1'b1;
                    end
                    else
                    begin
                        n_res          = 2'd1;
                        res0.kind      = KIND_DICT;
                        res0.slot      = dict_slot_reg;
                        res0.value     = {in_byte_reg, low_byte_reg};
                        low_seen_next  = 1'b0;
                        dict_slot_next = dict_slot_reg + 8'd1;
                        dict_left_next = dict_left_reg - 8'd1;
                        if (dict_left_reg == 8'd1)
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                end
                PH_COUNT:
                begin
                    n_res      = 2'd1;
                    res0.kind  = KIND_COUNT;
                    res0.value = {8'd0, in_byte_reg};
                    phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    body_next = nib_lo.st;
                    if (nib_hi.fire && nib_lo.fire)
                    begin
                        n_res     = 2'd2;
                        res0      = nib_hi.res;
                        res1      = nib_lo.res;
                        res1.last = 1'b1;
                    end
                    else if (nib_hi.fire)
                    begin
                        n_res     = 2'd1;
                        res0      = nib_hi.res;
                        res0.last = 1'b1;
                    end
                    else if (nib_lo.fire)
                    begin
                        n_res     = 2'd1;
                        res0      = nib_lo.res;
                        res0.last = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_FLAGS;
                end
            endcase
        end

        // The final byte of a message returns the parser to its reset state.
        if (in_last_reg)
        begin
            phase_next     = PH_FLAGS;
            dict_left_next = 8'd0;
            dict_slot_next = 8'd0;
            low_seen_next  = 1'b0;
            low_byte_next  = 8'd0;
            rejecting_next = 1'b0;
            body_next      = '0;
        end
    end

    // Result queue update.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (proc_fire)
        begin
            head_next = res0;
            tail_next = res1;
            cnt_next  = n_res;
        end
        else if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_last_reg   <= 1'b0;
            phase_reg     <= PH_FLAGS;
            dict_left_reg <= 8'd0;
            dict_slot_reg <= 8'd0;
            low_seen_reg  <= 1'b0;
            low_byte_reg  <= 8'd0;
            rejecting_reg <= 1'b0;
            body_reg      <= '0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
                in_last_reg  <= s_axis_tlast;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire)
            begin
                phase_reg     <= phase_next;
                dict_left_reg <= dict_left_next;
                dict_slot_reg <= dict_slot_next;
                low_seen_reg  <= low_seen_next;
                low_byte_reg  <= low_byte_next;
                rejecting_reg <= rejecting_next;
                body_reg      <= body_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    // The queue holds at most two items.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("result queue overflow");

    // A rejected message yields nothing after its flags byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && rejecting_reg |-> n_res == 2'd0)
        else $error("item produced while rejecting");

    // Only a body byte can yield two items.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (n_res == 2'd2) |-> phase_reg == PH_BODY)
        else $error("two items outside the body");

    // A byte waiting in the input register is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc_fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending input byte lost");

endmodule
